// File: hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg: shared definitions for the similarity transform block
// Opcodes, register indexes, pipeline depths and the lane control struct.
// ----------------------------------------------------------------------------
package sct_pkg;

	// forward coefficients: 32-bit signed, 30 fraction bits
	localparam int COEF_W   = 32;
	localparam int FWD_FRAC = 30;

	// operand slice width of the pipelined multiplier (25x25 signed products)
	localparam int MUL_CHUNK = 24;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FWD_COS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FWD_SIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_COS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SIN  = 3'd5;

	localparam logic [1:0] OP_PT_INV  = 2'd0;
	localparam logic [1:0] OP_PT_FWD  = 2'd1;
	localparam logic [1:0] OP_BOX_INV = 2'd2;
	localparam logic [1:0] OP_BOX_FWD = 2'd3;

	localparam logic signed [COEF_W-1:0] FWD_COS_RST = 32'sh4000_0000;

	// one lane per rectangle corner
	localparam int NUM_LANES = 4;
	localparam int LANE_LAT  = 7;
	localparam int MERGE_LAT = 2;
	localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

	typedef struct packed {
		logic fwd;
		logic rect;
	} ctl_t;

endpackage

// File: hdl/sct_mul.sv
// ----------------------------------------------------------------------------
// sct_mul: pipelined signed multiplier
// Slices both operands into MUL_CHUNK-bit digits, forms the digit products,
// sums them per row and then across rows. Three register stages.
// ----------------------------------------------------------------------------
module sct_mul #(
	parameter int AW = 49,
	parameter int BW = 48
) (
	input  logic                     clk,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);

	localparam int CH  = sct_pkg::MUL_CHUNK;
	localparam int NA  = (AW + CH - 1) / CH;
	localparam int NB  = (BW + CH - 1) / CH;
	localparam int AXW = NA * CH;
	localparam int BXW = NB * CH;
	localparam int PW  = AW + BW;
	localparam int PPW = 2 * CH + 2;

	logic signed [AXW-1:0] a_ext;
	logic signed [BXW-1:0] b_ext;
	logic signed [CH:0]    a_dig [NA];
	logic signed [CH:0]    b_dig [NB];
	logic signed [PPW-1:0] pp_s1 [NA][NB];
	logic signed [PW-1:0]  row_sum [NA];
	logic signed [PW-1:0]  row_s2 [NA];
	logic signed [PW-1:0]  p_sum;
	logic signed [PW-1:0]  p_s3;

	// low digits are unsigned, the top digit carries the sign
	always_comb begin
		a_ext = AXW'(a);
		b_ext = BXW'(b);
		for (int i = 0; i < NA; i++) begin
			if (i == NA - 1) begin
				a_dig[i] = {a_ext[AXW-1], a_ext[i*CH +: CH]};
			end else begin
				a_dig[i] = {1'b0, a_ext[i*CH +: CH]};
			end
		end
		for (int j = 0; j < NB; j++) begin
			if (j == NB - 1) begin
				b_dig[j] = {b_ext[BXW-1], b_ext[j*CH +: CH]};
			end else begin
				b_dig[j] = {1'b0, b_ext[j*CH +: CH]};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= a_dig[i] * b_dig[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_sum[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_sum[i] = row_sum[i] + (PW'(pp_s1[i][j]) <<< (j * CH));
			end
		end
	end

	always_ff @(posedge clk) begin
		row_s2 <= row_sum;
	end

	always_comb begin
		p_sum = '0;
		for (int i = 0; i < NA; i++) begin
			p_sum = p_sum + (row_s2[i] <<< (i * CH));
		end
	end

	always_ff @(posedge clk) begin
		p_s3 <= p_sum;
	end

	assign p = p_s3;

endmodule

// File: hdl/sct_lane.sv
// ----------------------------------------------------------------------------
// sct_lane: maps one point through the forward or inverse transform
// Operand select, four pipelined products, sum, truncation toward zero and
// saturation. Seven register stages.
// ----------------------------------------------------------------------------
module sct_lane #(
	parameter int W = 48,
	parameter int F = 16
) (
	input  logic                                  clk,
	input  sct_pkg::ctl_t                         ctl,
	input  logic signed [W-1:0]                   in_x,
	input  logic signed [W-1:0]                   in_y,
	input  logic signed [W-1:0]                   org_x,
	input  logic signed [W-1:0]                   org_y,
	input  logic signed [sct_pkg::COEF_W-1:0]     fwd_cos,
	input  logic signed [sct_pkg::COEF_W-1:0]     fwd_sin,
	input  logic signed [W-1:0]                   inv_cos,
	input  logic signed [W-1:0]                   inv_sin,
	output logic signed [W-1:0]                   res_x,
	output logic signed [W-1:0]                   res_y,
	output logic                                  sat,
	output sct_pkg::ctl_t                         ctl_out
);

	localparam int AW     = W + 1;
	localparam int BW     = W;
	localparam int PW     = AW + BW;
	localparam int SW     = PW + 2;
	localparam int SH_FWD = sct_pkg::FWD_FRAC + F;

	localparam logic [W-1:0]         ONE_F    = W'(1) << F;
	localparam logic [W-1:0]         FMASK    = ONE_F - W'(1);
	localparam logic [SW-1:0]        DROP_FWD = (SW'(1) << SH_FWD) - SW'(1);
	localparam logic [SW-1:0]        DROP_INV = (SW'(1) << F) - SW'(1);
	localparam logic signed [SW-1:0] HI_INV   = (SW'(1) << (W - 1)) - SW'(1);
	localparam logic signed [SW-1:0] LO_INV   = -(SW'(1) << (W - 1));
	localparam logic signed [SW-1:0] HI_FWD   = (SW'(1) << (W - 1 - F)) - SW'(1);
	localparam logic signed [SW-1:0] LO_FWD   = -(SW'(1) << (W - 1 - F));

	logic signed [W-1:0]  fl_x, fl_y;
	logic signed [AW-1:0] ax_n, ay_n;
	logic signed [BW-1:0] bc_n, bs_n;
	logic signed [AW-1:0] a_x_s1, a_y_s1;
	logic signed [BW-1:0] b_c_s1, b_s_s1;
	logic signed [PW-1:0] p_xc, p_ys, p_yc, p_xs;
	logic signed [SW-1:0] off_x, off_y, sum_x_n, sum_y_n;
	logic signed [SW-1:0] sum_x_s5, sum_y_s5;
	logic signed [SW-1:0] tr_x_s6, tr_y_s6;
	logic [W:0]           cl_x, cl_y;
	logic signed [W-1:0]  res_x_s7, res_y_s7;
	logic                 sat_s7;
	sct_pkg::ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;

	// divide by 2^shift, rounding toward zero
	function automatic logic signed [SW-1:0] trunc0(input logic signed [SW-1:0] v,
			input logic fwd);
		logic signed [SW-1:0] q;
		logic                 drop;
		q    = fwd ? (v >>> SH_FWD) : (v >>> F);
		drop = fwd ? ((v & DROP_FWD) != '0) : ((v & DROP_INV) != '0);
		if (v[SW-1] && drop) begin
			q = q + SW'(1);
		end
		return q;
	endfunction

	// saturate to the output range; forward results carry a zero fraction
	function automatic logic [W:0] clamp(input logic signed [SW-1:0] v,
			input logic fwd);
		logic signed [SW-1:0] lo, hi, c;
		logic                 s;
		lo = fwd ? LO_FWD : LO_INV;
		hi = fwd ? HI_FWD : HI_INV;
		c  = v;
		s  = 1'b0;
		if (v < lo) begin
			c = lo;
			s = 1'b1;
		end else if (v > hi) begin
			c = hi;
			s = 1'b1;
		end
		if (fwd) begin
			return {s, W'(c <<< F)};
		end
		return {s, W'(c)};
	endfunction

	// screen input of the inverse map: drop the fraction toward zero
	always_comb begin
		fl_x = in_x & ~FMASK;
		fl_y = in_y & ~FMASK;
		if (in_x[W-1] && ((in_x & FMASK) != '0)) begin
			fl_x = fl_x + ONE_F;
		end
		if (in_y[W-1] && ((in_y & FMASK) != '0)) begin
			fl_y = fl_y + ONE_F;
		end
		ax_n = ctl.fwd ? AW'(in_x) : (AW'(fl_x) - AW'(org_x));
		ay_n = ctl.fwd ? AW'(in_y) : (AW'(fl_y) - AW'(org_y));
		bc_n = ctl.fwd ? BW'(fwd_cos) : inv_cos;
		bs_n = ctl.fwd ? BW'(fwd_sin) : inv_sin;
	end

	always_ff @(posedge clk) begin
		a_x_s1 <= ax_n;
		a_y_s1 <= ay_n;
		b_c_s1 <= bc_n;
		b_s_s1 <= bs_n;
		ctl_s1 <= ctl;
		ctl_s2 <= ctl_s1;
		ctl_s3 <= ctl_s2;
		ctl_s4 <= ctl_s3;
	end

	sct_mul #(.AW(AW), .BW(BW)) u_mul_xc (.clk(clk), .a(a_x_s1), .b(b_c_s1), .p(p_xc));
	sct_mul #(.AW(AW), .BW(BW)) u_mul_ys (.clk(clk), .a(a_y_s1), .b(b_s_s1), .p(p_ys));
	sct_mul #(.AW(AW), .BW(BW)) u_mul_yc (.clk(clk), .a(a_y_s1), .b(b_c_s1), .p(p_yc));
	sct_mul #(.AW(AW), .BW(BW)) u_mul_xs (.clk(clk), .a(a_x_s1), .b(b_s_s1), .p(p_xs));

	// origin is added here only in the forward map, scaled to the coefficient fraction
	always_comb begin
		off_x   = ctl_s4.fwd ? (SW'(org_x) <<< sct_pkg::FWD_FRAC) : SW'(0);
		off_y   = ctl_s4.fwd ? (SW'(org_y) <<< sct_pkg::FWD_FRAC) : SW'(0);
		sum_x_n = off_x + SW'(p_xc) + (ctl_s4.fwd ? -SW'(p_ys) : SW'(p_ys));
		sum_y_n = off_y + SW'(p_yc) + (ctl_s4.fwd ? SW'(p_xs) : -SW'(p_xs));
	end

	always_ff @(posedge clk) begin
		sum_x_s5 <= sum_x_n;
		sum_y_s5 <= sum_y_n;
		ctl_s5   <= ctl_s4;
		tr_x_s6  <= trunc0(sum_x_s5, ctl_s5.fwd);
		tr_y_s6  <= trunc0(sum_y_s5, ctl_s5.fwd);
		ctl_s6   <= ctl_s5;
	end

	always_comb begin
		cl_x = clamp(tr_x_s6, ctl_s6.fwd);
		cl_y = clamp(tr_y_s6, ctl_s6.fwd);
	end

	always_ff @(posedge clk) begin
		res_x_s7 <= cl_x[W-1:0];
		res_y_s7 <= cl_y[W-1:0];
		sat_s7   <= cl_x[W] | cl_y[W];
		ctl_s7   <= ctl_s6;
	end

	assign res_x   = res_x_s7;
	assign res_y   = res_y_s7;
	assign sat     = sat_s7;
	assign ctl_out = ctl_s7;

endmodule

// File: hdl/sct_merge.sv
// ----------------------------------------------------------------------------
// sct_merge: bounding box over the corner lanes
// Pairwise min/max and saturation OR in the first stage, final min/max in
// the second. Point requests take lane 0 alone.
// ----------------------------------------------------------------------------
module sct_merge #(
	parameter int W = 48
) (
	input  logic                                 clk,
	input  logic                                 rect,
	input  logic signed [W-1:0]                  xs [sct_pkg::NUM_LANES],
	input  logic signed [W-1:0]                  ys [sct_pkg::NUM_LANES],
	input  logic [sct_pkg::NUM_LANES-1:0]        sats,
	output logic signed [W-1:0]                  low_x,
	output logic signed [W-1:0]                  low_y,
	output logic signed [W-1:0]                  high_x,
	output logic signed [W-1:0]                  high_y,
	output logic                                 saturated
);

	logic signed [W-1:0] x [sct_pkg::NUM_LANES];
	logic signed [W-1:0] y [sct_pkg::NUM_LANES];
	logic                sat_n;
	logic signed [W-1:0] lo_x01_s1, lo_x23_s1, hi_x01_s1, hi_x23_s1;
	logic signed [W-1:0] lo_y01_s1, lo_y23_s1, hi_y01_s1, hi_y23_s1;
	logic                sat_s1;
	logic signed [W-1:0] low_x_s2, low_y_s2, high_x_s2, high_y_s2;
	logic                sat_s2;

	function automatic logic signed [W-1:0] smin(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		return (b < a) ? b : a;
	endfunction

	function automatic logic signed [W-1:0] smax(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		return (a < b) ? b : a;
	endfunction

	// for a point, every slot sees lane 0
	always_comb begin
		for (int i = 0; i < sct_pkg::NUM_LANES; i++) begin
			x[i] = rect ? xs[i] : xs[0];
			y[i] = rect ? ys[i] : ys[0];
		end
		sat_n = rect ? (|sats) : sats[0];
	end

	always_ff @(posedge clk) begin
		lo_x01_s1 <= smin(x[0], x[1]);
		lo_x23_s1 <= smin(x[2], x[3]);
		hi_x01_s1 <= smax(x[0], x[1]);
		hi_x23_s1 <= smax(x[2], x[3]);
		lo_y01_s1 <= smin(y[0], y[1]);
		lo_y23_s1 <= smin(y[2], y[3]);
		hi_y01_s1 <= smax(y[0], y[1]);
		hi_y23_s1 <= smax(y[2], y[3]);
		sat_s1    <= sat_n;
	end

	always_ff @(posedge clk) begin
		low_x_s2  <= smin(lo_x01_s1, lo_x23_s1);
		high_x_s2 <= smax(hi_x01_s1, hi_x23_s1);
		low_y_s2  <= smin(lo_y01_s1, lo_y23_s1);
		high_y_s2 <= smax(hi_y01_s1, hi_y23_s1);
		sat_s2    <= sat_s1;
	end

	assign low_x     = low_x_s2;
	assign low_y     = low_y_s2;
	assign high_x    = high_x_s2;
	assign high_y    = high_y_s2;
	assign saturated = sat_s2;

endmodule

// File: hdl/similarity_coord_transform_bbox.sv
// ----------------------------------------------------------------------------
// similarity_coord_transform_bbox: rotate/scale/translate points and boxes
// A request is taken on a clock edge with start high and busy low; opcode
// picks inverse or forward map, of one point or of a rectangle's corners.
// busy is high only during reset and for the first edge after it; from then
// on a request may be issued every cycle.
// Each result appears with done high, for one cycle, after passing the
// corner lanes (operand select, 3-stage sliced multiplier, sum, truncate,
// saturate) and then the min/max merge tree.
// Results leave in request order; the receiver takes every one and cannot
// stall the pipe. Four lanes, one per corner, run side by side.
// Coefficients go in through cfg_we/cfg_index/cfg_data; the user must write
// them only while no request is in flight (not enforced by the block). Reset
// restores the identity transform and drops any request in flight.
// ----------------------------------------------------------------------------
module similarity_coord_transform_bbox #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        opcode,
	input  logic signed [COORD_WIDTH-1:0]     first_x,
	input  logic signed [COORD_WIDTH-1:0]     first_y,
	input  logic signed [COORD_WIDTH-1:0]     second_x,
	input  logic signed [COORD_WIDTH-1:0]     second_y,
	input  logic                              cfg_we,
	input  logic [sct_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [COORD_WIDTH-1:0]            cfg_data,
	output logic                              done,
	output logic signed [COORD_WIDTH-1:0]     low_x,
	output logic signed [COORD_WIDTH-1:0]     low_y,
	output logic signed [COORD_WIDTH-1:0]     high_x,
	output logic signed [COORD_WIDTH-1:0]     high_y,
	output logic                              saturated
);

	localparam int NL = sct_pkg::NUM_LANES;
	localparam int PL = sct_pkg::PIPE_LAT;
	localparam logic [COORD_WIDTH-1:0] FMASK =
		(COORD_WIDTH'(1) << FRAC_BITS) - COORD_WIDTH'(1);

	logic signed [COORD_WIDTH-1:0]     origin_x_q, origin_y_q, inv_cos_q, inv_sin_q;
	logic signed [sct_pkg::COEF_W-1:0] fwd_cos_q, fwd_sin_q;
	logic                              busy_q;
	logic [PL-1:0]                     vld_q;
	logic                              accept;
	sct_pkg::ctl_t                     ctl_in;
	sct_pkg::ctl_t                     lane_ctl [NL];
	logic signed [COORD_WIDTH-1:0]     cx [NL];
	logic signed [COORD_WIDTH-1:0]     cy [NL];
	logic signed [COORD_WIDTH-1:0]     lx [NL];
	logic signed [COORD_WIDTH-1:0]     ly [NL];
	logic [NL-1:0]                     lsat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			fwd_cos_q  <= sct_pkg::FWD_COS_RST;
			fwd_sin_q  <= '0;
			inv_cos_q  <= COORD_WIDTH'(1) << FRAC_BITS;
			inv_sin_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sct_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
				sct_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
				sct_pkg::REG_FWD_COS:  fwd_cos_q  <= cfg_data[sct_pkg::COEF_W-1:0];
				sct_pkg::REG_FWD_SIN:  fwd_sin_q  <= cfg_data[sct_pkg::COEF_W-1:0];
				sct_pkg::REG_INV_COS:  inv_cos_q  <= cfg_data;
				sct_pkg::REG_INV_SIN:  inv_sin_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept = start && !busy_q;

	// hold off requests until the first edge after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_q  <= '0;
		end else begin
			busy_q <= 1'b0;
			vld_q  <= {vld_q[PL-2:0], accept};
		end
	end

	assign busy = busy_q;
	assign done = vld_q[PL-1];

	always_comb begin
		ctl_in.fwd  = (opcode == sct_pkg::OP_PT_FWD) || (opcode == sct_pkg::OP_BOX_FWD);
		ctl_in.rect = (opcode == sct_pkg::OP_BOX_INV) || (opcode == sct_pkg::OP_BOX_FWD);
		// corners: left-top, right-top, right-bottom, left-bottom
		cx[0] = first_x;
		cy[0] = first_y;
		cx[1] = second_x;
		cy[1] = first_y;
		cx[2] = second_x;
		cy[2] = second_y;
		cx[3] = first_x;
		cy[3] = second_y;
	end

	for (genvar g = 0; g < NL; g++) begin : g_lane
		sct_lane #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_lane (
			.clk     (clk),
			.ctl     (ctl_in),
			.in_x    (cx[g]),
			.in_y    (cy[g]),
			.org_x   (origin_x_q),
			.org_y   (origin_y_q),
			.fwd_cos (fwd_cos_q),
			.fwd_sin (fwd_sin_q),
			.inv_cos (inv_cos_q),
			.inv_sin (inv_sin_q),
			.res_x   (lx[g]),
			.res_y   (ly[g]),
			.sat     (lsat[g]),
			.ctl_out (lane_ctl[g])
		);
	end

	sct_merge #(.W(COORD_WIDTH)) u_merge (
		.clk       (clk),
		.rect      (lane_ctl[0].rect),
		.xs        (lx),
		.ys        (ly),
		.sats      (lsat),
		.low_x     (low_x),
		.low_y     (low_y),
		.high_x    (high_x),
		.high_y    (high_y),
		.saturated (saturated)
	);

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PL))
		else $error("result strobe without a matching request");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (low_x <= high_x) && (low_y <= high_y))
		else $error("box minimum above maximum");

	a_point_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		done && (($past(opcode, PL) == sct_pkg::OP_PT_INV) ||
		($past(opcode, PL) == sct_pkg::OP_PT_FWD))
		|-> (low_x == high_x) && (low_y == high_y))
		else $error("point result with differing low and high");

	a_fwd_integer: assert property (@(posedge clk) disable iff (!arst_n)
		done && (($past(opcode, PL) == sct_pkg::OP_PT_FWD) ||
		($past(opcode, PL) == sct_pkg::OP_BOX_FWD))
		|-> ((low_x & FMASK) == '0) && ((high_y & FMASK) == '0))
		else $error("forward result with nonzero fraction");

endmodule
